// ===== sv/pbd_pkg.sv =====
package pbd_pkg;

  // window and sample geometry
  localparam int WINDOW_LENGTH   = 20;
  localparam int SAMPLE_W        = 10;
  localparam int SAMPLE_LSB      = 3;
  localparam int RAW_W           = 16;
  localparam int TICK_W          = 16;
  localparam int THRESHOLD_RESET = 250;

  // derived widths
  localparam int WIN_IDX_W = $clog2(WINDOW_LENGTH);
  localparam int SUM_W     = SAMPLE_W + WIN_IDX_W;
  localparam int THR_W     = SUM_W + 1;

  // reciprocal for the divide by the window length, exact over the whole sum range
  localparam int RECIP_SHIFT = SAMPLE_W + 2 * WIN_IDX_W;
  localparam int RECIP       = (2 ** RECIP_SHIFT + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
  localparam int RECIP_W     = RECIP_SHIFT - WIN_IDX_W + 2;
  localparam int PROD_W      = SUM_W + RECIP_W;

  // stream widths
  localparam int IN_DATA_W  = RAW_W;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USED_W = SAMPLE_W + 3 + TICK_W;

  // item kind carried in tuser
  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_t;

  // per item result flags carried down the pipeline
  typedef struct packed {
    logic              beat_start;
    logic              beat_release;
    logic              level_high;
    logic [TICK_W-1:0] elapsed_ms;
  } beat_flags_t;

endpackage

// ===== sv/pulse_beat_detector_unit.sv =====
// pipeline: a result passes the first stage register and then the output register before it is offered
// throughput: one item per cycle while the output is not stalled; the window sum is
//   a running total; the window-length divide is a reciprocal multiply in the output stage
// reset (rst, synchronous, active high): threshold back to 250, window unprimed,
//   level flag low, tick count and pipeline valid bits cleared
module pulse_beat_detector_unit import pbd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  threshold_we,
  input  logic [SAMPLE_W-1:0]   threshold_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] raw_word
  input  logic [0:0]            s_tuser,   // [0] command
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // [9:0] average, [10] beat_start,
                                           // [11] beat_release, [12] level_high,
                                           // [28:13] elapsed_ms, rest zero
);

  // state
  logic [SAMPLE_W-1:0]  window [WINDOW_LENGTH];
  logic [WIN_IDX_W-1:0] wr_pos;
  logic [SUM_W-1:0]     window_sum;
  logic                 primed;
  logic                 level_flag;
  logic [TICK_W-1:0]    tick_count;
  logic [THR_W-1:0]     thr_lo;
  logic [THR_W-1:0]     thr_hi;

  // pipeline
  logic                 p1_valid;
  logic [SUM_W-1:0]     p1_sum;
  beat_flags_t          p1_flags;
  logic [SAMPLE_W-1:0]  out_avg;
  beat_flags_t          out_flags;

  // combinational
  logic                 out_en;
  logic                 in_xfer;
  cmd_t                 cmd;
  logic [SAMPLE_W-1:0]  sample;
  logic [SUM_W-1:0]     sum_next;
  logic [TICK_W-1:0]    tick_inc;
  logic                 above;
  logic                 below;
  beat_flags_t          flags_next;
  logic [PROD_W-1:0]    avg_prod;

  // handshake
  assign out_en   = !m_tvalid || m_tready;
  assign s_tready = !p1_valid || out_en;
  assign in_xfer  = s_tvalid && s_tready;
  assign cmd      = cmd_t'(s_tuser[0]);

  // threshold scaled to sum units: avg > thr is sum >= len*(thr+1), avg < thr is sum < len*thr
  always_ff @(posedge clk) begin
    if (rst) begin
      thr_lo <= THR_W'(WINDOW_LENGTH * THRESHOLD_RESET);
      thr_hi <= THR_W'(WINDOW_LENGTH * (THRESHOLD_RESET + 1));
    end else if (threshold_we) begin
      thr_lo <= THR_W'(threshold_wdata) * THR_W'(WINDOW_LENGTH);
      thr_hi <= THR_W'(threshold_wdata) * THR_W'(WINDOW_LENGTH) + THR_W'(WINDOW_LENGTH);
    end
  end

  // window sum update and crossing test
  always_comb begin
    sample   = s_tdata[SAMPLE_LSB +: SAMPLE_W];
    sum_next = primed ? (window_sum - SUM_W'(window[wr_pos]) + SUM_W'(sample))
                      : (SUM_W'(sample) * SUM_W'(WINDOW_LENGTH));
    above    = {1'b0, sum_next} >= thr_hi;
    below    = {1'b0, sum_next} < thr_lo;
    tick_inc = (tick_count == {TICK_W{1'b1}}) ? tick_count : tick_count + TICK_W'(1);

    if (cmd == CMD_TICK) begin
      flags_next.beat_start   = 1'b0;
      flags_next.beat_release = 1'b0;
      flags_next.level_high   = level_flag;
      flags_next.elapsed_ms   = tick_inc;
    end else begin
      flags_next.beat_start   = !level_flag && above;
      flags_next.beat_release = level_flag && below;
      flags_next.level_high   = (level_flag && !below) || (!level_flag && above);
      flags_next.elapsed_ms   = tick_count;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum <= '0;
      primed     <= 1'b0;
      level_flag <= 1'b0;
      tick_count <= '0;
      wr_pos     <= '0;
    end else if (in_xfer) begin
      if (cmd == CMD_TICK) begin
        tick_count <= tick_inc;
      end else begin
        window_sum <= sum_next;
        primed     <= 1'b1;
        level_flag <= flags_next.level_high;
        if (flags_next.beat_release) begin
          tick_count <= '0;
        end
        if (primed) begin
          wr_pos <= (wr_pos == WIN_IDX_W'(WINDOW_LENGTH - 1)) ? '0 : wr_pos + WIN_IDX_W'(1);
        end
      end
    end
  end

  // sample window, first sample fills every entry
  always_ff @(posedge clk) begin
    if (in_xfer && cmd == CMD_SAMPLE) begin
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        if (!primed || wr_pos == WIN_IDX_W'(i)) begin
          window[i] <= sample;
        end
      end
    end
  end

  // first stage: sum and flags of the accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (s_tready) begin
      p1_valid <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      p1_sum   <= (cmd == CMD_TICK) ? window_sum : sum_next;
      p1_flags <= flags_next;
    end
  end

  // output stage: average by reciprocal multiply
  assign avg_prod = PROD_W'(p1_sum) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_en) begin
      m_tvalid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && p1_valid) begin
      out_avg   <= avg_prod[RECIP_SHIFT +: SAMPLE_W];
      out_flags <= p1_flags;
    end
  end

  // result packing
  assign m_tdata = {{(OUT_DATA_W - OUT_USED_W){1'b0}},
                    out_flags.elapsed_ms,
                    out_flags.level_high,
                    out_flags.beat_release,
                    out_flags.beat_start,
                    out_avg};

endmodule

// ===== tb/sv/tb_pulse_beat_detector_unit.sv =====
module tb_pulse_beat_detector_unit;
  import pbd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // one result item as it leaves the block
  typedef struct packed {
    logic [2:0]          pad;
    logic [TICK_W-1:0]   elapsed_ms;
    logic                level_high;
    logic                beat_release;
    logic                beat_start;
    logic [SAMPLE_W-1:0] average;
  } beat_result_t;

  // tracks the detector state and checks every result transfer in order
  class beat_checker;
    logic [SAMPLE_W-1:0] thr;
    logic [SAMPLE_W-1:0] win [WINDOW_LENGTH];
    int                  win_sum;
    int                  wr_pos;
    bit                  primed;
    bit                  level;
    logic [TICK_W-1:0]   ticks;
    beat_result_t        expected_beats [$];
    int                  errors;

    function new();
      thr     = SAMPLE_W'(THRESHOLD_RESET);
      win_sum = 0;
      wr_pos  = 0;
      primed  = 0;
      level   = 0;
      ticks   = '0;
      errors  = 0;
      foreach (win[i]) win[i] = '0;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    // work out the result of one accepted input transfer
    function void note_item(cmd_t cmd, logic [RAW_W-1:0] raw);
      beat_result_t        r;
      logic [SAMPLE_W-1:0] s;
      r = '0;
      if (cmd == CMD_TICK) begin
        if (ticks != {TICK_W{1'b1}}) ticks = ticks + TICK_W'(1);
        r.elapsed_ms = ticks;
        r.average    = primed ? SAMPLE_W'(win_sum / WINDOW_LENGTH) : '0;
        r.level_high = level;
      end else begin
        s = raw[SAMPLE_LSB +: SAMPLE_W];
        // first sample after reset fills the whole window
        if (!primed) begin
          foreach (win[i]) win[i] = s;
          win_sum = int'(s) * WINDOW_LENGTH;
          wr_pos  = 0;
          primed  = 1;
        end else begin
          win_sum     = win_sum - int'(win[wr_pos]) + int'(s);
          win[wr_pos] = s;
          wr_pos      = (wr_pos + 1) % WINDOW_LENGTH;
        end
        r.average    = SAMPLE_W'(win_sum / WINDOW_LENGTH);
        r.elapsed_ms = ticks;
        // crossings: equal to threshold does nothing
        if (!level && r.average > thr) begin
          level        = 1;
          r.beat_start = 1'b1;
        end else if (level && r.average < thr) begin
          level          = 0;
          r.beat_release = 1'b1;
          ticks          = '0;
        end
        r.level_high = level;
      end
      expected_beats.push_back(r);
    endfunction

    // compare one result transfer with the oldest expectation
    function void check_result(logic [OUT_DATA_W-1:0] data);
      beat_result_t act;
      beat_result_t exp_r;
      act = beat_result_t'(data);
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: avg=%0d start=%0b rel=%0b lvl=%0b ms=%0d",
                   act.average, act.beat_start, act.beat_release, act.level_high,
                   act.elapsed_ms);
        return;
      end
      exp_r = expected_beats.pop_front();
      if (act !== exp_r) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: exp avg=%0d start=%0b rel=%0b lvl=%0b ms=%0d pad=%0d",
                   exp_r.average, exp_r.beat_start, exp_r.beat_release,
                   exp_r.level_high, exp_r.elapsed_ms, exp_r.pad);
          $display("          got avg=%0d start=%0b rel=%0b lvl=%0b ms=%0d pad=%0d",
                   act.average, act.beat_start, act.beat_release,
                   act.level_high, act.elapsed_ms, act.pad);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  threshold_we = 1'b0;
  logic [SAMPLE_W-1:0]   threshold_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  beat_checker sb = new();

  // sender burst state
  int burst_left = 4;
  int max_gap    = 8;
  bit valid_up   = 0;

  // receiver stall state
  int results_seen = 0;
  int hold_left    = 0;
  bit held_once    = 0;
  int mode         = 0;
  int mode_left    = 50;
  bit toggle_ph    = 0;

  pulse_beat_detector_unit dut (
    .clk             (clk),
    .rst             (rst),
    .threshold_we    (threshold_we),
    .threshold_wdata (threshold_wdata),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata)
  );

  always #10 clk = ~clk;

  // run limit
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // receiver: check each result transfer, then pick the next ready value
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        sb.check_result(m_tdata);
        results_seen++;
      end
      // one long hold-off so the block fills up and stalls its input
      if (!held_once && results_seen >= 300) begin
        held_once = 1;
        hold_left = 400;
      end
      if (mode_left <= 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(32, 200);
      end
      mode_left--;
      toggle_ph = ~toggle_ph;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= $urandom_range(0, 1);
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= toggle_ph;
        endcase
      end
    end
  end

  // offer one item and wait for its transfer; bursts end in a random gap when max_gap is above zero
  task automatic offer(cmd_t cmd, logic [RAW_W-1:0] raw);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= raw;
    s_tuser  <= cmd;
    valid_up = 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(cmd, raw);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 16);
      if (max_gap > 0) begin
        gap = $urandom_range(1, max_gap);
        s_tvalid <= 1'b0;
        valid_up = 0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop sending and wait until every expected result has arrived
  task automatic quiesce();
    if (valid_up) begin
      s_tvalid <= 1'b0;
      valid_up = 0;
    end
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(logic [SAMPLE_W-1:0] value);
    threshold_we    <= 1'b1;
    threshold_wdata <= value;
    @(posedge clk);
    threshold_we <= 1'b0;
    sb.thr = value;
  endtask

  function automatic int clip_sample(int v);
    return (v < 0) ? 0 : ((v > 1023) ? 1023 : v);
  endfunction

  function automatic logic [RAW_W-1:0] pack_raw(int s);
    logic [2:0] hi;
    logic [2:0] lo;
    hi = 3'($urandom);
    lo = 3'($urandom);
    return {hi, SAMPLE_W'(s), lo};
  endfunction

  // segments of samples above, at or below the threshold or at a random level, with noise and ticks
  task automatic run_wave(int n_items);
    int done;
    int seg_len;
    int target;
    int thr_i;
    int s;
    done  = 0;
    thr_i = int'(sb.thr);
    while (done < n_items) begin
      seg_len = $urandom_range(5, 40);
      case ($urandom_range(0, 3))
        0: target = clip_sample(thr_i + int'($urandom_range(1, 200)));
        1: target = clip_sample(thr_i - int'($urandom_range(1, 200)));
        2: target = thr_i;
        default: target = $urandom_range(0, 1023);
      endcase
      repeat (seg_len) begin
        if ($urandom_range(0, 3) == 0) begin
          offer(CMD_TICK, RAW_W'($urandom));
        end else if ($urandom_range(0, 9) == 0) begin
          offer(CMD_SAMPLE, RAW_W'($urandom));
        end else begin
          s = clip_sample(target + int'($urandom_range(0, 16)) - 8);
          offer(CMD_SAMPLE, pack_raw(s));
        end
        done++;
        if ($urandom_range(0, 299) == 0) quiesce();
      end
    end
  endtask

  // main sequence
  initial begin
    logic [SAMPLE_W-1:0] thr_list [5];

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: ticks before any sample, window fill at the threshold,
    // full-scale rise, fall to zero for a release, unused raw bits
    offer(CMD_TICK, 16'hFFFF);
    offer(CMD_TICK, 16'h0000);
    offer(CMD_SAMPLE, {3'b111, 10'd250, 3'b111});
    offer(CMD_SAMPLE, 16'hFFFF);
    offer(CMD_TICK, 16'h1234);
    offer(CMD_SAMPLE, 16'hFFFF);
    repeat (7) offer(CMD_SAMPLE, 16'h0000);
    offer(CMD_TICK, 16'h0000);
    offer(CMD_SAMPLE, 16'hE007);
    offer(CMD_SAMPLE, 16'h1FF8);
    offer(CMD_TICK, 16'hFFFF);
    quiesce();

    // random phases over several thresholds, extremes included
    thr_list[0] = '0;
    thr_list[1] = {SAMPLE_W{1'b1}};
    thr_list[2] = SAMPLE_W'($urandom_range(0, 1023));
    thr_list[3] = SAMPLE_W'($urandom_range(100, 900));
    thr_list[4] = SAMPLE_W'(THRESHOLD_RESET);
    foreach (thr_list[i]) begin
      write_threshold(thr_list[i]);
      run_wave(400);
      quiesce();
    end

    // long run of back to back ticks, then a few samples
    write_threshold(SAMPLE_W'($urandom_range(1, 1022)));
    max_gap = 0;
    repeat (100) offer(CMD_TICK, RAW_W'($urandom));
    max_gap = 8;
    repeat (12) offer(CMD_SAMPLE, RAW_W'($urandom));
    quiesce();

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== pulse_beat_detector_unit.f =====
sv/pbd_pkg.sv
sv/pulse_beat_detector_unit.sv
tb/sv/tb_pulse_beat_detector_unit.sv
